// File: hdl/ssm_pkg.sv
package ssm_pkg;

    localparam int unsigned ZONE_COUNT = 4;

    localparam logic [31:0] PERIOD_RESET = 32'd5000;

    // count / 1000 == (count * RECIP_M) >> RECIP_SHIFT for any 32-bit count
    localparam logic [31:0] DIV_K       = 32'd1000;
    localparam logic [28:0] RECIP_M     = 29'd274877907;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam int unsigned QUOT_W      = 23;

    typedef enum logic [1:0] {
        SCR_COUNT = 2'd0,
        SCR_PEAK  = 2'd1,
        SCR_LOW   = 2'd2,
        SCR_OOM   = 2'd3
    } t_screen;

    typedef logic [0:4][2:0]            t_glyph;
    typedef logic [7:0][11:0]           t_rows;
    typedef logic [ZONE_COUNT-1:0][2:0] t_heights;

    typedef struct packed {
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_digits;

    localparam t_glyph DIGIT_FONT [10] = '{
        {3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, {3'd2, 3'd6, 3'd2, 3'd2, 3'd7},
        {3'd7, 3'd1, 3'd7, 3'd4, 3'd7}, {3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
        {3'd5, 3'd5, 3'd7, 3'd1, 3'd1}, {3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
        {3'd7, 3'd4, 3'd7, 3'd5, 3'd7}, {3'd7, 3'd1, 3'd1, 3'd1, 3'd1},
        {3'd7, 3'd5, 3'd7, 3'd5, 3'd7}, {3'd7, 3'd5, 3'd7, 3'd1, 3'd7}
    };
    localparam t_glyph FONT_H = {3'd5, 3'd5, 3'd7, 3'd5, 3'd5};
    localparam t_glyph FONT_L = {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
    localparam t_glyph FONT_O = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
    localparam t_glyph FONT_M = {3'd5, 3'd7, 3'd7, 3'd5, 3'd5};

    // floor(level * 5 / 254) as thresholds
    function automatic logic [2:0] bar_height(input logic [7:0] lv);
        logic [2:0] h;
        if (lv >= 8'd254) h = 3'd5;
        else if (lv >= 8'd204) h = 3'd4;
        else if (lv >= 8'd153) h = 3'd3;
        else if (lv >= 8'd102) h = 3'd2;
        else if (lv >= 8'd51) h = 3'd1;
        else h = 3'd0;
        return h;
    endfunction

    function automatic t_screen next_screen(input t_screen s);
        t_screen n;
        case (s)
            SCR_COUNT: n = SCR_PEAK;
            SCR_PEAK:  n = SCR_LOW;
            SCR_LOW:   n = SCR_COUNT;
            default:   n = SCR_PEAK;
        endcase
        return n;
    endfunction

    function automatic t_glyph digit_glyph(input logic [3:0] d);
        t_glyph g;
        if (d < 4'd10) g = DIGIT_FONT[d];
        else g = '0;
        return g;
    endfunction

    // glyph bit 2 lands on the leftmost column x0, top row is matrix row 1
    function automatic t_rows put_glyph(input t_rows rows, input int unsigned x0,
                                        input t_glyph g);
        t_rows t;
        t = rows;
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (g[r][2-c]) t[1+r][x0+c] = 1'b1;
            end
        end
        return t;
    endfunction

    function automatic t_rows render(input t_screen scr, input t_digits dg,
                                     input logic big, input t_heights hts);
        t_rows rows;
        rows = '0;
        case (scr)
            SCR_COUNT: begin
                rows = put_glyph(rows, 0, digit_glyph(dg.hund));
                rows = put_glyph(rows, 4, digit_glyph(dg.tens));
                rows = put_glyph(rows, 8, digit_glyph(dg.ones));
                rows[0][11] = big;
            end
            SCR_PEAK, SCR_LOW: begin
                rows = put_glyph(rows, 0, (scr == SCR_PEAK) ? FONT_H : FONT_L);
                for (int z = 0; z < ZONE_COUNT; z++) begin
                    for (int r = 1; r < 6; r++) begin
                        if (r >= 6 - int'(hts[z])) rows[r][4+2*z] = 1'b1;
                    end
                end
            end
            SCR_OOM: begin
                rows = put_glyph(rows, 0, FONT_O);
                rows = put_glyph(rows, 4, FONT_O);
                rows = put_glyph(rows, 8, FONT_M);
            end
            default: begin
                rows = '0;
            end
        endcase
        return rows;
    endfunction

endpackage

// File: hdl/ssm_if.sv
interface ssm_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [31:0] sample_count;
    logic [7:0]  max_level_0;
    logic [7:0]  max_level_1;
    logic [7:0]  max_level_2;
    logic [7:0]  max_level_3;
    logic [7:0]  min_level_0;
    logic [7:0]  min_level_1;
    logic [7:0]  min_level_2;
    logic [7:0]  min_level_3;
    logic        out_of_memory;

    modport source (
        output valid, now_ms, sample_count,
        output max_level_0, max_level_1, max_level_2, max_level_3,
        output min_level_0, min_level_1, min_level_2, min_level_3,
        output out_of_memory,
        input  ready
    );
    modport sink (
        input  valid, now_ms, sample_count,
        input  max_level_0, max_level_1, max_level_2, max_level_3,
        input  min_level_0, min_level_1, min_level_2, min_level_3,
        input  out_of_memory,
        output ready
    );
endinterface

interface ssm_frame_if;
    logic        valid;
    logic        ready;
    logic [11:0] row_0;
    logic [11:0] row_1;
    logic [11:0] row_2;
    logic [11:0] row_3;
    logic [11:0] row_4;
    logic [11:0] row_5;
    logic [11:0] row_6;
    logic [11:0] row_7;
    logic [1:0]  screen_shown;

    modport source (
        output valid, row_0, row_1, row_2, row_3, row_4, row_5, row_6, row_7,
        output screen_shown,
        input  ready
    );
    modport sink (
        input  valid, row_0, row_1, row_2, row_3, row_4, row_5, row_6, row_7,
        input  screen_shown,
        output ready
    );
endinterface

// File: hdl/ssm_rotator.sv
module ssm_rotator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata,
    input  logic             i_step,
    input  logic [31:0]      i_now_ms,
    input  logic             i_oom,
    output ssm_pkg::t_screen o_screen
);
    import ssm_pkg::*;

    t_screen     r_cur, n_cur;
    logic [31:0] r_last, n_last;
    logic [31:0] r_period;
    logic [31:0] w_diff;
    logic        w_swap;
    t_screen     w_live;

    always_comb begin
        w_diff = i_now_ms - r_last;
        w_swap = !i_oom && (w_diff >= r_period);
        w_live = w_swap ? next_screen(r_cur) : r_cur;
        n_cur  = r_cur;
        n_last = r_last;
        if (i_step && w_swap) begin
            n_cur  = w_live;
            n_last = i_now_ms;
        end
        // stray state 3 draws as the low bars, or as the peak bars when it swaps
        if (i_oom) begin
            o_screen = SCR_OOM;
        end else if (w_live == SCR_OOM) begin
            o_screen = SCR_LOW;
        end else begin
            o_screen = w_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= SCR_COUNT;
            r_last   <= '0;
            r_period <= PERIOD_RESET;
        end else begin
            r_cur  <= n_cur;
            r_last <= n_last;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    a_no_oom_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur != SCR_OOM)
        else $error("rotation state reached the OOM code");

    a_oom_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_oom) |=> (r_cur == $past(r_cur) && r_last == $past(r_last)))
        else $error("rotation moved during an OOM request");

    a_swap_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_swap) |=> (r_last == $past(i_now_ms)))
        else $error("swap time not taken from the request");

endmodule

// File: hdl/ssm_digits.sv
module ssm_digits (
    input  logic             i_clk,
    input  logic             i_en_quot,
    input  logic [31:0]      i_count,
    input  logic             i_en_rem,
    output ssm_pkg::t_digits o_digits
);
    import ssm_pkg::*;

    logic [60:0]       w_prod;
    logic [QUOT_W-1:0] r_quot;
    logic [31:0]       r_count;
    logic [31:0]       w_back;
    logic [31:0]       w_diff;
    logic [9:0]        r_rem;
    logic [6:0]        w_rem100;
    logic [6:0]        w_rem10;

    // stage 1: quotient by reciprocal multiply
    assign w_prod = 61'(i_count) * 61'(RECIP_M);

    always_ff @(posedge i_clk) begin
        if (i_en_quot) begin
            r_quot  <= w_prod[RECIP_SHIFT +: QUOT_W];
            r_count <= i_count;
        end
    end

    // stage 2: remainder, always below 1000
    assign w_back = 32'(r_quot) * DIV_K;
    assign w_diff = r_count - w_back;

    always_ff @(posedge i_clk) begin
        if (i_en_rem) begin
            r_rem <= w_diff[9:0];
        end
    end

    // decimal split by threshold compares
    always_comb begin
        o_digits.hund = '0;
        w_rem100      = r_rem[6:0];
        for (int k = 1; k < 10; k++) begin
            if (r_rem >= 10'(100 * k)) begin
                o_digits.hund = 4'(k);
                w_rem100      = 7'(r_rem - 10'(100 * k));
            end
        end
        o_digits.tens = '0;
        w_rem10       = w_rem100;
        for (int k = 1; k < 10; k++) begin
            if (w_rem100 >= 7'(10 * k)) begin
                o_digits.tens = 4'(k);
                w_rem10       = w_rem100 - 7'(10 * k);
            end
        end
        o_digits.ones = w_rem10[3:0];
    end

endmodule

// File: hdl/stats_screen_matrix_renderer_top.sv
// Statistics screen renderer for a 12x8 LED matrix.
//
// i_req (sink): one render request per transfer: time stamp, sample count,
//   four peak and four low levels, out-of-memory flag.
// o_frame (source): one frame per request, rows 0..7 (bit x = column x)
//   and the screen code (0 count, 1 peak bars, 2 low bars, 3 OOM).
// i_cfg_we / i_cfg_wdata: screen period in ms, written while idle.
//
// Pipeline: a request lands in the input reg, then passes the reciprocal
//   multiply, remainder and frame reg stages before its frame is valid.
// Throughput: one request per cycle; the four-stage pipeline advances
//   whenever the frame register is empty or being taken, so a stalled
//   receiver only fills the empty stages before i_req.ready drops.
// Screen rotation is decided as a request leaves the input register, so
//   frames follow the request order exactly.
// Reset (synchronous, active low) empties the pipeline, returns to the
//   count screen with swap time 0, and sets the period to 5000 ms.
module stats_screen_matrix_renderer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    ssm_req_if.sink     i_req,
    ssm_frame_if.source o_frame
);
    import ssm_pkg::*;

    // handshake / stage advance
    logic adv_a, adv_b, adv_c, adv_d;

    // stage A: request register
    logic        r_a_v;
    logic [31:0] r_a_now;
    logic [31:0] r_a_count;
    logic [3:0][7:0] r_a_max;
    logic [3:0][7:0] r_a_min;
    logic        r_a_oom;

    // stage B/C: screen, bar heights, overflow pixel
    logic     r_b_v, r_c_v;
    t_screen  r_b_screen, r_c_screen;
    t_heights r_b_h, r_c_h;
    logic     r_b_big, r_c_big;

    // stage D: output frame
    logic     r_d_v;
    t_rows    r_d_rows;
    t_screen  r_d_screen;

    t_screen  w_screen;
    t_heights w_h;
    t_digits  w_digits;

    assign adv_d = !r_d_v || o_frame.ready;
    assign adv_c = !r_c_v || adv_d;
    assign adv_b = !r_b_v || adv_c;
    assign adv_a = !r_a_v || adv_b;
    assign i_req.ready = adv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (adv_a) r_a_v <= i_req.valid;
            if (adv_b) r_b_v <= r_a_v;
            if (adv_c) r_c_v <= r_b_v;
            if (adv_d) r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_now    <= i_req.now_ms;
            r_a_count  <= i_req.sample_count;
            r_a_max[0] <= i_req.max_level_0;
            r_a_max[1] <= i_req.max_level_1;
            r_a_max[2] <= i_req.max_level_2;
            r_a_max[3] <= i_req.max_level_3;
            r_a_min[0] <= i_req.min_level_0;
            r_a_min[1] <= i_req.min_level_1;
            r_a_min[2] <= i_req.min_level_2;
            r_a_min[3] <= i_req.min_level_3;
            r_a_oom    <= i_req.out_of_memory;
        end
    end

    // rotation state steps once per request, in order
    ssm_rotator u_rotator (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (adv_b && r_a_v),
        .i_now_ms    (r_a_now),
        .i_oom       (r_a_oom),
        .o_screen    (w_screen)
    );

    // bar heights of the zone set the screen shows
    always_comb begin
        for (int z = 0; z < ZONE_COUNT; z++) begin
            w_h[z] = bar_height((w_screen == SCR_PEAK) ? r_a_max[z] : r_a_min[z]);
        end
    end

    ssm_digits u_digits (
        .i_clk     (i_clk),
        .i_en_quot (adv_b),
        .i_count   (r_a_count),
        .i_en_rem  (adv_c),
        .o_digits  (w_digits)
    );

    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_b_screen <= w_screen;
            r_b_h      <= w_h;
            r_b_big    <= (r_a_count >= DIV_K);
        end
        if (adv_c) begin
            r_c_screen <= r_b_screen;
            r_c_h      <= r_b_h;
            r_c_big    <= r_b_big;
        end
        if (adv_d) begin
            r_d_screen <= r_c_screen;
            r_d_rows   <= render(r_c_screen, w_digits, r_c_big, r_c_h);
        end
    end

    assign o_frame.valid        = r_d_v;
    assign o_frame.row_0        = r_d_rows[0];
    assign o_frame.row_1        = r_d_rows[1];
    assign o_frame.row_2        = r_d_rows[2];
    assign o_frame.row_3        = r_d_rows[3];
    assign o_frame.row_4        = r_d_rows[4];
    assign o_frame.row_5        = r_d_rows[5];
    assign o_frame.row_6        = r_d_rows[6];
    assign o_frame.row_7        = r_d_rows[7];
    assign o_frame.screen_shown = r_d_screen;

endmodule

// File: tb/tb.sv
module tb;
    import ssm_pkg::*;

    // Run limit in clock cycles, set well above what the slowest correct run
    // (both sides idling heavily) needs.
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned ITEMS_PER_PHASE = 190;
    localparam int unsigned PHASES = 6;

    // Screen period for each random phase: mid, zero, reset value, max,
    // one, odd small value.
    localparam logic [31:0] PHASE_PERIOD [PHASES] = '{
        32'd100, 32'd0, 32'd5000, 32'hFFFF_FFFF, 32'd1, 32'd37
    };

    // Glyph rows, top row first, bit 2 = leftmost column.
    // Entries 0..9 are digits, then H, L, O, M.
    localparam int unsigned SYM_H = 10;
    localparam int unsigned SYM_L = 11;
    localparam int unsigned SYM_O = 12;
    localparam int unsigned SYM_M = 13;
    localparam logic [2:0] GLYPH_ROWS [14][5] = '{
        '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, '{3'd2, 3'd6, 3'd2, 3'd2, 3'd7},
        '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7}, '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
        '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1}, '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
        '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7}, '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1},
        '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7}, '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7},
        '{3'd5, 3'd5, 3'd7, 3'd5, 3'd5}, '{3'd4, 3'd4, 3'd4, 3'd4, 3'd7},
        '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, '{3'd5, 3'd7, 3'd7, 3'd5, 3'd5}
    };

    // Levels on and around the bar height steps (h = level*5/254).
    localparam logic [7:0] LEVEL_EDGES [12] = '{
        8'd0, 8'd50, 8'd51, 8'd101, 8'd102, 8'd152,
        8'd153, 8'd203, 8'd204, 8'd253, 8'd254, 8'd255
    };

    typedef struct packed {
        logic [31:0]     now_ms;
        logic [31:0]     sample_count;
        logic [3:0][7:0] peak;
        logic [3:0][7:0] low;
        logic            oom;
    } t_request;

    typedef struct packed {
        logic [7:0][11:0] rows;
        t_screen          screen;
    } t_frame;

    // Tracks rotation state, predicts the frame of each accepted request
    // and checks frames in order against those predictions.
    class frame_tracker;
        logic [31:0] period_ms;
        t_screen     screen;
        logic [31:0] last_swap_ms;
        t_frame      expected_frames [$];
        int unsigned mismatches;
        int unsigned frames_seen;

        function new();
            period_ms    = PERIOD_RESET;
            screen       = SCR_COUNT;
            last_swap_ms = '0;
            mismatches   = 0;
            frames_seen  = 0;
        endfunction

        function void set_period(logic [31:0] value);
            period_ms = value;
        endfunction

        function int unsigned pending();
            return expected_frames.size();
        endfunction

        function logic [7:0][11:0] stamp(logic [7:0][11:0] rows, int unsigned col,
                                         int unsigned sym);
            for (int r = 0; r < 5; r++)
                for (int c = 0; c < 3; c++)
                    if (GLYPH_ROWS[sym][r][2-c]) rows[1+r][col+c] = 1'b1;
            return rows;
        endfunction

        function void note_request(t_request req);
            t_frame      f;
            logic [31:0] elapsed;
            logic [31:0] shown_val;
            logic [7:0]  lvl;
            int unsigned h;
            f = '0;
            if (req.oom) begin
                // OOM text; rotation state frozen
                f.rows   = stamp(f.rows, 0, SYM_O);
                f.rows   = stamp(f.rows, 4, SYM_O);
                f.rows   = stamp(f.rows, 8, SYM_M);
                f.screen = SCR_OOM;
            end else begin
                elapsed = req.now_ms - last_swap_ms;  // wraps mod 2^32
                if (elapsed >= period_ms) begin
                    case (screen)
                        SCR_COUNT: screen = SCR_PEAK;
                        SCR_PEAK:  screen = SCR_LOW;
                        SCR_LOW:   screen = SCR_COUNT;
                        default:   screen = SCR_PEAK;
                    endcase
                    last_swap_ms = req.now_ms;
                end
                f.screen = screen;
                if (screen == SCR_COUNT) begin
                    shown_val = req.sample_count % 32'd1000;
                    f.rows = stamp(f.rows, 0, shown_val / 100);
                    f.rows = stamp(f.rows, 4, (shown_val / 10) % 10);
                    f.rows = stamp(f.rows, 8, shown_val % 10);
                    if (req.sample_count >= 32'd1000) f.rows[0][11] = 1'b1;
                end else begin
                    f.rows = stamp(f.rows, 0, (screen == SCR_PEAK) ? SYM_H : SYM_L);
                    for (int z = 0; z < ZONE_COUNT; z++) begin
                        lvl = (screen == SCR_PEAK) ? req.peak[z] : req.low[z];
                        h = 32'(lvl) * 5 / 254;
                        for (int y = 0; y < h; y++) f.rows[5-y][4+2*z] = 1'b1;
                    end
                end
            end
            expected_frames.push_back(f);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("frame %0d %s: expected %h, got %h",
                         frames_seen, field, want, got);
        endfunction

        function void check_frame(t_frame got);
            t_frame want;
            frames_seen++;
            if (expected_frames.size() == 0) begin
                report("with no request pending, screen", '0, got.screen);
                return;
            end
            want = expected_frames.pop_front();
            for (int k = 0; k < 8; k++)
                if (got.rows[k] !== want.rows[k])
                    report($sformatf("row_%0d", k), want.rows[k], got.rows[k]);
            if (got.screen !== want.screen)
                report("screen_shown", want.screen, got.screen);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    ssm_req_if   req_bus ();
    ssm_frame_if frame_bus ();

    frame_tracker frames = new();

    int unsigned req_idle_pct;    // sender idle chance per cycle, percent
    int unsigned frame_idle_pct;  // receiver stall chance per cycle, percent
    logic [31:0] last_now;        // time stamp of the previous generated request
    int unsigned cycle_count;

    stats_screen_matrix_renderer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_bus),
        .o_frame     (frame_bus)
    );

    always #4 clk = ~clk;

    // Watchdog: a hung handshake or a lost frame ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("stats_screen_matrix_renderer_top: mismatch");
            $finish;
        end
    end

    // Receiver back-pressure, re-rolled every falling edge.
    always @(negedge clk) begin
        frame_bus.ready <= ($urandom_range(99) >= frame_idle_pct);
    end

    // Frame transfers are sampled at the rising edge, before the block's
    // registers update, so the check never races the design.
    always @(posedge clk) begin : take_frames
        t_frame got;
        if (rst_n && frame_bus.valid && frame_bus.ready) begin
            got.rows   = {frame_bus.row_7, frame_bus.row_6, frame_bus.row_5,
                          frame_bus.row_4, frame_bus.row_3, frame_bus.row_2,
                          frame_bus.row_1, frame_bus.row_0};
            got.screen = t_screen'(frame_bus.screen_shown);
            frames.check_frame(got);
        end
    end

    // Called at a falling edge; returns at the falling edge after the
    // transfer. valid is only touched once per edge, so back-to-back
    // requests keep it high.
    task automatic send_request(input t_request r);
        while ($urandom_range(99) < req_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.now_ms        <= r.now_ms;
        req_bus.sample_count  <= r.sample_count;
        req_bus.max_level_0   <= r.peak[0];
        req_bus.max_level_1   <= r.peak[1];
        req_bus.max_level_2   <= r.peak[2];
        req_bus.max_level_3   <= r.peak[3];
        req_bus.min_level_0   <= r.low[0];
        req_bus.min_level_1   <= r.low[1];
        req_bus.min_level_2   <= r.low[2];
        req_bus.min_level_3   <= r.low[3];
        req_bus.out_of_memory <= r.oom;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        frames.note_request(r);
        @(negedge clk);
    endtask

    // Period writes only happen with the pipeline drained. Every request
    // yields a frame, so an empty prediction queue means the block is idle.
    task automatic write_period(input logic [31:0] value);
        req_bus.valid <= 1'b0;
        while (frames.pending() != 0) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        frames.set_period(value);
    endtask

    function automatic t_request directed_item(logic [31:0] now, logic [31:0] count,
                                               logic [31:0] peak, logic [31:0] low,
                                               logic oom);
        t_request r;
        r.now_ms       = now;
        r.sample_count = count;
        r.peak         = peak;
        r.low          = low;
        r.oom          = oom;
        return r;
    endfunction

    function automatic logic [7:0] pick_level();
        if ($urandom_range(99) < 30) return LEVEL_EDGES[$urandom_range(11)];
        return 8'($urandom);
    endfunction

    // Mostly a forward-moving clock with steps scaled to the period, some
    // requests right at the swap boundary, and some arbitrary jumps.
    function automatic t_request random_request();
        t_request    r;
        logic [31:0] span;
        int unsigned pick;
        span = frames.period_ms;
        pick = $urandom_range(99);
        if (pick < 70) begin
            if (span == 0 || span > 32'd100000) r.now_ms = last_now + $urandom_range(3000);
            else r.now_ms = last_now + $urandom_range(span + span / 2 + 1);
        end else if (pick < 85) begin
            // exactly at or one short of the swap point
            r.now_ms = frames.last_swap_ms + span - $urandom_range(1);
        end else begin
            r.now_ms = $urandom;
        end
        last_now = r.now_ms;

        pick = $urandom_range(99);
        if (pick < 30) r.sample_count = $urandom_range(999);
        else if (pick < 50) r.sample_count = $urandom_range(1010, 990);
        else if (pick < 60) r.sample_count = 32'hFFFF_FFFF - $urandom_range(5);
        else r.sample_count = $urandom;

        for (int z = 0; z < 4; z++) begin
            r.peak[z] = pick_level();
            r.low[z]  = pick_level();
        end
        r.oom = ($urandom_range(9) == 0);
        return r;
    endfunction

    task automatic set_idling(input int unsigned sender_pct, input int unsigned recv_pct);
        req_idle_pct   = sender_pct;
        frame_idle_pct = recv_pct;
    endtask

    initial begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        cycle_count           = 0;
        last_now              = '0;
        req_bus.valid         = 1'b0;
        req_bus.now_ms        = '0;
        req_bus.sample_count  = '0;
        req_bus.max_level_0   = '0;
        req_bus.max_level_1   = '0;
        req_bus.max_level_2   = '0;
        req_bus.max_level_3   = '0;
        req_bus.min_level_0   = '0;
        req_bus.min_level_1   = '0;
        req_bus.min_level_2   = '0;
        req_bus.min_level_3   = '0;
        req_bus.out_of_memory = 1'b0;
        frame_bus.ready       = 1'b0;
        set_idling(23, 60);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset period of 5000 ms first: count screen at the
        // extremes, swap exactly at the period, OOM freeze, bar height steps,
        // corner pixel, and a swap measured across the 32-bit wrap.
        send_request(directed_item(32'd0, 32'd0, 32'h0, 32'h0, 1'b0));
        send_request(directed_item(32'd4999, 32'd999, 32'hFFFF_FFFF, 32'h0, 1'b0));
        send_request(directed_item(32'd5000, 32'd1000, 32'h00FD_FEFF, 32'hFFFF_FFFF,
                                   1'b0));
        send_request(directed_item(32'hFFFF_FFFF, 32'd123, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   1'b1));
        send_request(directed_item(32'd9999, 32'd456, 32'h6566_3233, 32'h0, 1'b0));
        send_request(directed_item(32'd10000, 32'd78, 32'h0, 32'h98CC_CB99, 1'b0));
        send_request(directed_item(32'd15000, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0));
        send_request(directed_item(32'd15001, 32'd1000, 32'h0, 32'h0, 1'b1));
        send_request(directed_item(32'd20000, 32'd1789, 32'h3366_99CC, 32'h0, 1'b0));
        send_request(directed_item(32'd25000, 32'd5, 32'h0, 32'hFE01_3280, 1'b0));
        send_request(directed_item(32'd30000, 32'd678, 32'h0, 32'h0, 1'b0));
        send_request(directed_item(32'hFFFF_F000, 32'd901, 32'h1122_4488, 32'h0, 1'b0));
        send_request(directed_item(32'h0000_0388, 32'd1034, 32'h0, 32'hAA55_F00F, 1'b0));

        // Zero period: every non-OOM request rotates.
        write_period(32'd0);
        send_request(directed_item(32'd7, 32'd42, 32'hFFFF_FFFF, 32'h0, 1'b0));
        send_request(directed_item(32'd7, 32'd567, 32'h0, 32'hFFFF_FFFF, 1'b0));
        send_request(directed_item(32'd7, 32'd890, 32'h0, 32'h0, 1'b1));
        send_request(directed_item(32'd7, 32'd3210, 32'h0, 32'h0, 1'b0));
        send_request(directed_item(32'd7, 32'd0, 32'h8080_8080, 32'h0, 1'b0));

        // Max period: only a difference of all ones rotates.
        write_period(32'hFFFF_FFFF);
        send_request(directed_item(32'd6, 32'd999, 32'h0, 32'h7F7F_7F7F, 1'b0));
        send_request(directed_item(32'd7, 32'd999, 32'h0, 32'h0, 1'b0));
        send_request(directed_item(32'd5, 32'd1000, 32'h0, 32'h0, 1'b0));
        last_now = 32'd5;

        // Random phases: sender-idle/receiver-stall mix swaps halfway, then
        // both sides run flat out for the last two phases.
        for (int p = 0; p < PHASES; p++) begin
            write_period(PHASE_PERIOD[p]);
            case (p / 2)
                0:       set_idling(23, 60);
                1:       set_idling(60, 23);
                default: set_idling(0, 0);
            endcase
            repeat (ITEMS_PER_PHASE) send_request(random_request());
        end
        req_bus.valid <= 1'b0;

        // Drain, then give the four-stage pipeline time to show strays.
        while (frames.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (frames.mismatches == 0)
            $display("stats_screen_matrix_renderer_top: match");
        else
            $display("stats_screen_matrix_renderer_top: mismatch");
        $finish;
    end

endmodule
